// ===== sv/bcdf_pkg.sv =====
// Shared types and constants for the binomial CDF block.
// Used by the channel interfaces, controller, datapath and top level.
`timescale 1ns / 1ps

package bcdf_pkg;

    // Field widths of the transfer payloads
    localparam int TRIAL_W = 6;
    localparam int PROB_W  = 33;
    localparam int FRAC_W  = 32;

    // Q1.32 one
    localparam logic [PROB_W-1:0] FX_ONE = 33'h1_0000_0000;

    // Default trial limit
    localparam int DEFAULT_MAX_TRIALS = 32;

    // Commands from controller to datapath, at most one multiplier user per cycle
    typedef struct packed {
        logic load;      // capture a new item and clear the accumulators
        logic pre_step;  // store (1-p)^j, advance the power and the coefficient row
        logic rd_first;  // fetch (1-p)^n for the first term
        logic weight;    // weight = p^i * (1-p)^(n-i)
        logic term;      // term = C(n,i) * weight
        logic acc;       // add the term, advance p^i, shift the coefficient row
        logic out_load;  // move the finished sum into the output register
    } bcdf_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic pre_last;   // last power of (1-p) is being stored
        logic term_last;  // current term is the term for k
    } bcdf_status_t;

endpackage

// ===== sv/bcdf_in_if.sv =====
// Input channel: valid/ready handshake carrying one CDF query.
// Depends on bcdf_pkg for the field widths.
`timescale 1ns / 1ps

interface bcdf_in_if;
    import bcdf_pkg::*;

    logic                valid;
    logic                ready;
    logic [TRIAL_W-1:0]  trial_count;
    logic [TRIAL_W-1:0]  success_count;
    logic [PROB_W-1:0]   probability;

    modport source (output valid, output trial_count, output success_count,
                    output probability, input ready);
    modport sink   (input valid, input trial_count, input success_count,
                    input probability, output ready);
endinterface

// ===== sv/bcdf_out_if.sv =====
// Output channel: valid/ready handshake carrying one CDF result.
// Depends on bcdf_pkg for the field widths.
`timescale 1ns / 1ps

interface bcdf_out_if;
    import bcdf_pkg::*;

    logic               valid;
    logic               ready;
    logic [PROB_W-1:0]  cumulative;
    logic               saturated;

    modport source (output valid, output cumulative, output saturated, input ready);
    modport sink   (input valid, input cumulative, input saturated, output ready);
endinterface

// ===== sv/bcdf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`timescale 1ns / 1ps

module bcdf_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 33
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/bcdf_ctrl.sv =====
// Sequencer for the binomial CDF: steps the datapath through the power
// table fill and the per-term loop. Depends on bcdf_pkg.
`timescale 1ns / 1ps

module bcdf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  bcdf_pkg::bcdf_status_t st,
    output bcdf_pkg::bcdf_cmd_t    cmd
);
    import bcdf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRE    = 3'd1;
    localparam logic [2:0] S_RD0    = 3'd2;
    localparam logic [2:0] S_WEIGHT = 3'd3;
    localparam logic [2:0] S_TERM   = 3'd4;
    localparam logic [2:0] S_ACC    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Decode state into datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                cmd.pre_step = 1'b1;
                if (st.pre_last)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                cmd.rd_first = 1'b1;
                state_next   = S_WEIGHT;
            end
            S_WEIGHT:
            begin
                cmd.weight = 1'b1;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = st.term_last ? S_FIN : S_WEIGHT;
            end
            S_FIN:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

// ===== sv/bcdf_dp.sv =====
// Datapath for the binomial CDF: shared 32x32 multiplier, Pascal row of
// coefficients, power table RAM and saturating accumulator. Depends on bcdf_pkg, bcdf_ram.
`timescale 1ns / 1ps

module bcdf_dp #(
    parameter int MAX_TRIALS = bcdf_pkg::DEFAULT_MAX_TRIALS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bcdf_pkg::bcdf_cmd_t           cmd,
    output bcdf_pkg::bcdf_status_t        st,
    input  logic [bcdf_pkg::TRIAL_W-1:0]  trial_count,
    input  logic [bcdf_pkg::TRIAL_W-1:0]  success_count,
    input  logic [bcdf_pkg::PROB_W-1:0]   probability,
    output logic [bcdf_pkg::PROB_W-1:0]   cumulative,
    output logic                          saturated
);
    import bcdf_pkg::*;

    localparam int DEPTH  = MAX_TRIALS + 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int COEF_W = MAX_TRIALS;        // C(n,i) < 2^n
    localparam int TERM_W = COEF_W + FRAC_W;

    // Item registers
    logic [IDX_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [PROB_W-1:0]  p_reg, p_next;
    logic [PROB_W-1:0]  q_reg, q_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    // Work registers
    logic [PROB_W-1:0]  qacc_reg, qacc_next;
    logic [PROB_W-1:0]  pp_reg, pp_next;
    logic [PROB_W-1:0]  weight_reg, weight_next;
    logic [TERM_W-1:0]  term_reg, term_next;
    logic [PROB_W-1:0]  sum_reg, sum_next;
    logic               sat_reg, sat_next;
    logic [COEF_W-1:0]  row_reg [DEPTH];
    logic [COEF_W-1:0]  row_next [DEPTH];

    // Output registers
    logic [PROB_W-1:0]  cumulative_reg, cumulative_next;
    logic               saturated_reg, saturated_next;

    // Input clamps
    logic [IDX_W-1:0]   n_clamp;
    logic [IDX_W-1:0]   k_clamp;
    logic [PROB_W-1:0]  p_clamp;

    // Multiplier and RAM signals
    logic [PROB_W-1:0]  fx_a, fx_b, fx_res;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        prod;
    logic [TERM_W-1:0]  term_res;
    logic [PROB_W-1:0]  room;
    logic               over;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [PROB_W-1:0]  ram_rdata;

    // Clamp n to the limit, k to n, p to one
    assign n_clamp = (trial_count > TRIAL_W'(MAX_TRIALS)) ? IDX_W'(MAX_TRIALS)
                                                         : trial_count[IDX_W-1:0];
    assign k_clamp = (success_count > TRIAL_W'(n_clamp)) ? n_clamp
                                                         : success_count[IDX_W-1:0];
    assign p_clamp = (probability > FX_ONE) ? FX_ONE : probability;

    assign st.pre_last  = (idx_reg == n_reg);
    assign st.term_last = (idx_reg == k_reg);

    // Select multiplier operands; one product per cycle
    always_comb
    begin
        if (cmd.pre_step)
        begin
            fx_a = qacc_reg;
            fx_b = q_reg;
        end
        else if (cmd.weight)
        begin
            fx_a = pp_reg;
            fx_b = ram_rdata;
        end
        else
        begin
            fx_a = pp_reg;
            fx_b = p_reg;
        end
        if (cmd.term)
        begin
            mul_a = 32'(row_reg[0]);
            mul_b = weight_reg[FRAC_W-1:0];
        end
        else
        begin
            mul_a = fx_a[FRAC_W-1:0];
            mul_b = fx_b[FRAC_W-1:0];
        end
    end

    assign prod = mul_a * mul_b;

    // A factor of exactly one passes the other factor through
    assign fx_res = fx_a[FRAC_W] ? fx_b :
                    fx_b[FRAC_W] ? fx_a : {1'b0, prod[63:FRAC_W]};
    assign term_res = weight_reg[FRAC_W] ? {row_reg[0], {FRAC_W{1'b0}}}
                                         : prod[TERM_W-1:0];

    // Saturating add of the current term
    assign room = FX_ONE - sum_reg;
    assign over = (term_reg > TERM_W'(room));

    // Power table read: first term at n, then one ahead of the loop
    assign ram_re    = cmd.rd_first || (cmd.acc && !st.term_last);
    assign ram_raddr = cmd.acc ? (n_reg - idx_reg - IDX_W'(1)) : (n_reg - idx_reg);

    bcdf_ram #(
        .WIDTH (PROB_W),
        .DEPTH (DEPTH)
    ) u_qpow_ram (
        .clk   (clk),
        .we    (cmd.pre_step),
        .waddr (idx_reg),
        .wdata (qacc_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next-state logic for the work registers
    always_comb
    begin
        n_next          = n_reg;
        k_next          = k_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        idx_next        = idx_reg;
        qacc_next       = qacc_reg;
        pp_next         = pp_reg;
        weight_next     = weight_reg;
        term_next       = term_reg;
        sum_next        = sum_reg;
        sat_next        = sat_reg;
        cumulative_next = cumulative_reg;
        saturated_next  = saturated_reg;
        for (int j = 0; j < DEPTH; j++)
        begin
            row_next[j] = row_reg[j];
        end

        if (cmd.load)
        begin
            n_next    = n_clamp;
            k_next    = k_clamp;
            p_next    = p_clamp;
            q_next    = FX_ONE - p_clamp;
            idx_next  = '0;
            qacc_next = FX_ONE;
            pp_next   = FX_ONE;
            sum_next  = '0;
            sat_next  = 1'b0;
            row_next[0] = COEF_W'(1);
            for (int j = 1; j < DEPTH; j++)
            begin
                row_next[j] = '0;
            end
        end

        // Fill the power table and build Pascal row n
        if (cmd.pre_step)
        begin
            qacc_next = fx_res;
            if (st.pre_last)
            begin
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
                for (int j = 1; j < DEPTH; j++)
                begin
                    row_next[j] = row_reg[j] + row_reg[j-1];
                end
            end
        end

        if (cmd.weight)
        begin
            weight_next = fx_res;
        end

        if (cmd.term)
        begin
            term_next = term_res;
        end

        // Accumulate, advance p^i, shift the next coefficient into place
        if (cmd.acc)
        begin
            if (over)
            begin
                sum_next = FX_ONE;
                sat_next = 1'b1;
            end
            else
            begin
                sum_next = sum_reg + term_reg[PROB_W-1:0];
            end
            pp_next  = fx_res;
            idx_next = idx_reg + IDX_W'(1);
            for (int j = 0; j < DEPTH - 1; j++)
            begin
                row_next[j] = row_reg[j+1];
            end
            row_next[DEPTH-1] = '0;
        end

        if (cmd.out_load)
        begin
            cumulative_next = sum_reg;
            saturated_next  = sat_reg;
        end
    end

    // Index counter is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        k_reg          <= k_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        qacc_reg       <= qacc_next;
        pp_reg         <= pp_next;
        weight_reg     <= weight_next;
        term_reg       <= term_next;
        sum_reg        <= sum_next;
        sat_reg        <= sat_next;
        cumulative_reg <= cumulative_next;
        saturated_reg  <= saturated_next;
        for (int j = 0; j < DEPTH; j++)
        begin
            row_reg[j] <= row_next[j];
        end
    end

    assign cumulative = cumulative_reg;
    assign saturated  = saturated_reg;
endmodule

// ===== sv/binomial_cdf_fixed.sv =====
// Binomial CDF in unsigned Q1.32: sums C(n,i) p^i (1-p)^(n-i) for i = 0..min(k,n),
// saturating at 1.0 with a flag. One query at a time: a query transferred in is
// finished before the next one can be taken. The work per query is set by the
// single shared 32x32 multiplier: one product per power of (1-p) while the power
// table RAM is filled, then three per term (weight, coefficient times weight, next
// power of p). A finished result waits in the output register while the next
// query is taken.
`timescale 1ns / 1ps

module binomial_cdf_fixed #(
    parameter int MAX_TRIALS = bcdf_pkg::DEFAULT_MAX_TRIALS
) (
    input  logic     clk,
    input  logic     rst_n,
    bcdf_in_if.sink  query,
    bcdf_out_if.source answer
);
    import bcdf_pkg::*;

    bcdf_cmd_t    cmd;
    bcdf_status_t st;
    logic         in_ready;
    logic         out_valid;

    // Sequencer
    bcdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (query.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (answer.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Arithmetic
    bcdf_dp #(
        .MAX_TRIALS (MAX_TRIALS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .trial_count   (query.trial_count),
        .success_count (query.success_count),
        .probability   (query.probability),
        .cumulative    (answer.cumulative),
        .saturated     (answer.saturated)
    );

    assign query.ready  = in_ready;
    assign answer.valid = out_valid;

`ifndef NO_ASSERTIONS
    // The shared multiplier and accumulator serve one step per cycle
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.pre_step, cmd.rd_first, cmd.weight, cmd.term, cmd.acc}))
        else $error("more than one datapath step in a cycle");

    // Each term product is accumulated in the following cycle
    a_term_acc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.term |=> cmd.acc)
        else $error("term product not accumulated");

    // A result never overwrites one still waiting for transfer
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!answer.valid || answer.ready))
        else $error("output register overwritten");

    // A saturated result reads exactly one, and no result exceeds one
    a_sat_one: assert property (@(posedge clk) disable iff (!rst_n)
        answer.valid |-> ((answer.cumulative <= FX_ONE)
                          && (!answer.saturated || (answer.cumulative == FX_ONE))))
        else $error("cumulative out of range");
`endif
endmodule
